// ===== sv/tfr_pkg.sv =====
// Shared constants of the three-format RISC core: item ops, opcodes,
// result kinds and fault codes. No dependencies.
package tfr_pkg;

  // Item ops on the input channel
  localparam logic [1:0] ITEM_LOAD  = 2'd0;
  localparam logic [1:0] ITEM_START = 2'd1;
  localparam logic [1:0] ITEM_STEP  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_DEC  = 3'd1;
  localparam logic [2:0] KIND_HEX  = 3'd2;
  localparam logic [2:0] KIND_NL   = 3'd3;
  localparam logic [2:0] KIND_BYTE = 3'd4;

  // Fault codes
  localparam logic [2:0] FLT_NONE = 3'd0;
  localparam logic [2:0] FLT_PC   = 3'd1;
  localparam logic [2:0] FLT_OPC  = 3'd2;
  localparam logic [2:0] FLT_WADR = 3'd3;
  localparam logic [2:0] FLT_BADR = 3'd4;
  localparam logic [2:0] FLT_CHK  = 3'd5;
  localparam logic [2:0] FLT_DIV0 = 3'd6;

  // Register format opcodes
  localparam logic [5:0] OP_MOV  = 6'd0;
  localparam logic [5:0] OP_MVN  = 6'd1;
  localparam logic [5:0] OP_ADD  = 6'd2;
  localparam logic [5:0] OP_SUB  = 6'd3;
  localparam logic [5:0] OP_MUL  = 6'd4;
  localparam logic [5:0] OP_DIV  = 6'd5;
  localparam logic [5:0] OP_MOD  = 6'd6;
  localparam logic [5:0] OP_CMP  = 6'd7;
  // Immediate format opcodes
  localparam logic [5:0] OP_MOVI = 6'd16;
  localparam logic [5:0] OP_MVNI = 6'd17;
  localparam logic [5:0] OP_ADDI = 6'd18;
  localparam logic [5:0] OP_SUBI = 6'd19;
  localparam logic [5:0] OP_MULI = 6'd20;
  localparam logic [5:0] OP_DIVI = 6'd21;
  localparam logic [5:0] OP_MODI = 6'd22;
  localparam logic [5:0] OP_CMPI = 6'd23;
  localparam logic [5:0] OP_CHKI = 6'd24;
  // Memory and I/O opcodes
  localparam logic [5:0] OP_LDW  = 6'd32;
  localparam logic [5:0] OP_LDB  = 6'd33;
  localparam logic [5:0] OP_POP  = 6'd34;
  localparam logic [5:0] OP_STW  = 6'd36;
  localparam logic [5:0] OP_STB  = 6'd37;
  localparam logic [5:0] OP_PSH  = 6'd38;
  localparam logic [5:0] OP_RD   = 6'd40;
  localparam logic [5:0] OP_WRD  = 6'd41;
  localparam logic [5:0] OP_WRH  = 6'd42;
  localparam logic [5:0] OP_WRL  = 6'd43;
  localparam logic [5:0] OP_RB   = 6'd44;
  localparam logic [5:0] OP_WRB  = 6'd45;
  // Branch opcodes
  localparam logic [5:0] OP_BEQ  = 6'd48;
  localparam logic [5:0] OP_BNE  = 6'd49;
  localparam logic [5:0] OP_BLT  = 6'd50;
  localparam logic [5:0] OP_BGE  = 6'd51;
  localparam logic [5:0] OP_BLE  = 6'd52;
  localparam logic [5:0] OP_BGT  = 6'd53;
  localparam logic [5:0] OP_BR   = 6'd56;
  localparam logic [5:0] OP_BSR  = 6'd57;
  localparam logic [5:0] OP_RET  = 6'd58;

  localparam logic [3:0] REG_LINK = 4'd14;
  localparam logic [3:0] REG_PC   = 4'd15;

endpackage

// ===== sv/tfr_if.sv =====
// Valid/ready channel interfaces of the three-format RISC core.
// Standalone; carries the item and result payloads.
interface tfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [8:0]  word_index;
  logic [31:0] load_word;
  logic [10:0] start_offset;
  logic [31:0] read_value;

  modport source (output valid, op, word_index, load_word, start_offset, read_value,
                  input ready);
  modport sink   (input valid, op, word_index, load_word, start_offset, read_value,
                  output ready);
endinterface

interface tfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [31:0] out_value;
  logic        input_used;
  logic        halted;
  logic [2:0]  fault;
  logic [11:0] program_counter;

  modport source (output valid, out_kind, out_value, input_used, halted, fault,
                  program_counter, input ready);
  modport sink   (input valid, out_kind, out_value, input_used, halted, fault,
                  program_counter, output ready);
endinterface

// ===== sv/three_format_risc_cpu_core.sv =====
// Top level of the three-format RISC core: sequencer, word memory,
// register file and shared iterative multiply/divide adder.
// Depends on tfr_pkg and the channel interfaces in tfr_if.sv.
//
//   channel | dir | contents
//   in_ch   | in  | op, word_index, load_word, start_offset, read_value
//   out_ch  | out | out_kind, out_value, input_used, halted, fault, program_counter
//
// Load and start items go from idle straight to the result state; multiply,
// divide and modulo make 32 passes through the shared adder.
// One item is in work at a time; in_ch.ready is high only while idle.
// A finished result waits in the output register; the core stalls in its
// last state until that register is free.
// Reset (rst_n low, synchronous) clears control state and register valid bits;
// word memory is not cleared.
module three_format_risc_cpu_core #(
  parameter int MEM_BYTES   = 4096,
  parameter int CODE_ORIGIN = 2048
) (
  input  logic clk,
  input  logic rst_n,
  tfr_in_if.sink    in_ch,
  tfr_out_if.source out_ch
);

  localparam int MEM_WORDS = MEM_BYTES / 4;
  localparam int AW        = $clog2(MEM_WORDS);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RDA, S_EXEC, S_ITER, S_MDFIN, S_MEMWB, S_WB2, S_COMMIT, S_DONE
  } state_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HALT, ST_FAULT} stat_t;

  state_t      state_r, state_nxt;
  stat_t       status_r, status_nxt;
  logic [2:0]  fault_r, fault_nxt;
  logic [31:0] pc_r, pc_nxt;
  logic [31:0] ir_r, ir_nxt;
  logic        z_r, z_nxt, n_r, n_nxt;
  logic [31:0] rdv_r, rdv_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [31:0] val_r, val_nxt;
  logic        used_r, used_nxt;
  logic [31:0] rb_r, rb_nxt, rx_r, rx_nxt;
  logic [31:0] next_r, next_nxt;
  logic [31:0] tmp_r, tmp_nxt;
  logic [AW+1:0] adr_r, adr_nxt;
  logic [31:0] acc_r, acc_nxt, mcand_r, mcand_nxt, mq_r, mq_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        sx_r, sx_nxt, sy_r, sy_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [2:0]  out_kind_r, out_kind_nxt;
  logic [31:0] out_val_r, out_val_nxt;
  logic        out_used_r, out_used_nxt;
  logic        out_halt_r, out_halt_nxt;
  logic [2:0]  out_fault_r, out_fault_nxt;
  logic [11:0] out_pc_r, out_pc_nxt;

  // Word memory ports
  logic [31:0]   mem [MEM_WORDS];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata_r;

  // Register file ports
  logic [31:0] rf_mem [16];
  logic [15:0] rf_vld_r;
  logic        rf_we, rf_re;
  logic [3:0]  rf_waddr, rf_ra0, rf_ra1;
  logic [31:0] rf_wdata, rd0_r, rd1_r;

  // Decode helpers
  logic [5:0]  opc;
  logic [3:0]  fa, fb;
  logic [31:0] cval, shv, pc4, br_tgt, adr, rb_abs, c_abs, ra;
  logic        adr_ok, md_mul, alu_sub, ge;
  logic [33:0] alu_a, alu_b, alu_sum;
  logic [31:0] idx32, start32, lane_byte;
  logic [4:0]  lane_sh;

  assign opc = ir_r[31:26];
  assign fa  = ir_r[25:22];
  assign fb  = ir_r[21:18];
  assign ra  = rd0_r;

  always_comb begin
    if (opc[5:4] == 2'b00) begin
      cval = rx_r;
    end else if (opc[5:4] != 2'b11) begin
      cval = {{14{ir_r[17]}}, ir_r[17:0]};
    end else begin
      cval = {{6{ir_r[25]}}, ir_r[25:0]};
    end
  end

  assign shv    = cval << fb;
  assign pc4    = pc_r + 32'd4;
  assign br_tgt = pc_r + {cval[29:0], 2'b00};
  assign rb_abs = rb_r[31] ? (32'd0 - rb_r) : rb_r;
  assign c_abs  = cval[31] ? (32'd0 - cval) : cval;

  // Memory address: base plus displacement, push subtracts, pop uses none
  always_comb begin
    if (opc == tfr_pkg::OP_POP) begin
      adr = rb_r;
    end else if (opc == tfr_pkg::OP_PSH) begin
      adr = rb_r - cval;
    end else begin
      adr = rb_r + cval;
    end
  end
  assign adr_ok = !adr[31] && (adr < 32'(MEM_BYTES));

  // Shared adder for multiply (add) and divide (trial subtract) passes
  assign md_mul  = (opc == tfr_pkg::OP_MUL) || (opc == tfr_pkg::OP_MULI);
  assign alu_sub = !md_mul;
  assign alu_a   = md_mul ? {2'b00, acc_r} : {1'b0, acc_r, mq_r[31]};
  assign alu_b   = md_mul ? {2'b00, (mq_r[0] ? mcand_r : 32'd0)} : {2'b00, mcand_r};
  assign alu_sum = alu_a + (alu_b ^ {34{alu_sub}}) + 34'(alu_sub);
  assign ge      = !alu_sum[33];

  assign idx32     = 32'(CODE_ORIGIN / 4) + 32'(in_ch.word_index);
  assign start32   = 32'(CODE_ORIGIN) + 32'(in_ch.start_offset) + 32'd4;
  assign lane_sh   = {adr_r[1:0], 3'b000};
  assign lane_byte = (mem_rdata_r >> lane_sh) & 32'h0000_00ff;

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_vld_r;
  assign out_ch.out_kind        = out_kind_r;
  assign out_ch.out_value       = out_val_r;
  assign out_ch.input_used      = out_used_r;
  assign out_ch.halted          = out_halt_r;
  assign out_ch.fault           = out_fault_r;
  assign out_ch.program_counter = out_pc_r;

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;   status_nxt = status_r; fault_nxt = fault_r;
    pc_nxt = pc_r;         ir_nxt = ir_r;         z_nxt = z_r;   n_nxt = n_r;
    rdv_nxt = rdv_r;       kind_nxt = kind_r;     val_nxt = val_r;
    used_nxt = used_r;     rb_nxt = rb_r;         rx_nxt = rx_r;
    next_nxt = next_r;     tmp_nxt = tmp_r;       adr_nxt = adr_r;
    acc_nxt = acc_r;       mcand_nxt = mcand_r;   mq_nxt = mq_r;
    cnt_nxt = cnt_r;       sx_nxt = sx_r;         sy_nxt = sy_r;
    out_vld_nxt = out_vld_r;   out_kind_nxt = out_kind_r; out_val_nxt = out_val_r;
    out_used_nxt = out_used_r; out_halt_nxt = out_halt_r;
    out_fault_nxt = out_fault_r; out_pc_nxt = out_pc_r;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0;
    mem_re = 1'b0; mem_raddr = '0;
    rf_we = 1'b0;  rf_waddr = '0;  rf_wdata = '0;
    rf_re = 1'b0;  rf_ra0 = '0;    rf_ra1 = '0;

    // Output register drains independently
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt = tfr_pkg::KIND_NONE;
          val_nxt  = '0;
          used_nxt = 1'b0;
          rdv_nxt  = in_ch.read_value;
          state_nxt = S_DONE;
          case (in_ch.op)
            tfr_pkg::ITEM_LOAD: begin
              if (idx32 < 32'(MEM_WORDS)) begin
                mem_we    = 1'b1;
                mem_waddr = idx32[AW-1:0];
                mem_wdata = in_ch.load_word;
              end
            end
            tfr_pkg::ITEM_START: begin
              if (in_ch.start_offset[1:0] != 2'b00 || start32 > 32'(MEM_BYTES)) begin
                fault_nxt  = tfr_pkg::FLT_PC;
                status_nxt = ST_FAULT;
              end else begin
                rf_we      = 1'b1;
                rf_waddr   = tfr_pkg::REG_LINK;
                pc_nxt     = start32 - 32'd4;
                fault_nxt  = tfr_pkg::FLT_NONE;
                status_nxt = ST_RUN;
              end
            end
            tfr_pkg::ITEM_STEP: begin
              if (status_r == ST_RUN) begin
                if (pc_r > 32'(MEM_BYTES - 4) || pc_r[1:0] != 2'b00) begin
                  fault_nxt  = tfr_pkg::FLT_PC;
                  status_nxt = ST_FAULT;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = pc_r[AW+1:2];
                  state_nxt = S_DEC;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // Instruction word arrives; read b and the low register field
      S_DEC: begin
        ir_nxt    = mem_rdata_r;
        rf_re     = 1'b1;
        rf_ra0    = mem_rdata_r[21:18];
        rf_ra1    = mem_rdata_r[3:0];
        state_nxt = S_RDA;
      end

      // Keep b and x, read a
      S_RDA: begin
        rb_nxt    = rd0_r;
        rx_nxt    = rd1_r;
        rf_re     = 1'b1;
        rf_ra0    = fa;
        rf_ra1    = ir_r[3:0];
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        next_nxt  = pc4;
        state_nxt = S_COMMIT;
        adr_nxt   = adr[AW+1:0];
        case (opc)
          tfr_pkg::OP_MOV, tfr_pkg::OP_MOVI: begin
            rf_we = 1'b1; rf_waddr = fa; rf_wdata = shv;
          end
          tfr_pkg::OP_MVN, tfr_pkg::OP_MVNI: begin
            rf_we = 1'b1; rf_waddr = fa; rf_wdata = 32'd0 - shv;
          end
          tfr_pkg::OP_ADD, tfr_pkg::OP_ADDI: begin
            rf_we = 1'b1; rf_waddr = fa; rf_wdata = rb_r + cval;
          end
          tfr_pkg::OP_SUB, tfr_pkg::OP_SUBI: begin
            rf_we = 1'b1; rf_waddr = fa; rf_wdata = rb_r - cval;
          end
          tfr_pkg::OP_MUL, tfr_pkg::OP_MULI: begin
            acc_nxt = '0; mcand_nxt = rb_r; mq_nxt = cval; cnt_nxt = '0;
            state_nxt = S_ITER;
          end
          tfr_pkg::OP_DIV, tfr_pkg::OP_DIVI, tfr_pkg::OP_MOD, tfr_pkg::OP_MODI: begin
            if (cval == 32'd0) begin
              fault_nxt = tfr_pkg::FLT_DIV0; status_nxt = ST_FAULT; state_nxt = S_DONE;
            end else begin
              acc_nxt = '0; mq_nxt = rb_abs; mcand_nxt = c_abs; cnt_nxt = '0;
              sx_nxt = rb_r[31]; sy_nxt = cval[31];
              state_nxt = S_ITER;
            end
          end
          tfr_pkg::OP_CMP, tfr_pkg::OP_CMPI: begin
            z_nxt = (rb_r == cval);
            n_nxt = ($signed(rb_r) < $signed(cval));
          end
          tfr_pkg::OP_CHKI: begin
            if (ra[31] || $signed(ra) >= $signed(cval)) begin
              fault_nxt = tfr_pkg::FLT_CHK; status_nxt = ST_FAULT; state_nxt = S_DONE;
            end
          end
          tfr_pkg::OP_LDW, tfr_pkg::OP_POP, tfr_pkg::OP_LDB, tfr_pkg::OP_STB: begin
            if (!adr_ok) begin
              fault_nxt  = (opc == tfr_pkg::OP_LDB || opc == tfr_pkg::OP_STB) ?
                           tfr_pkg::FLT_BADR : tfr_pkg::FLT_WADR;
              status_nxt = ST_FAULT;
              state_nxt  = S_DONE;
            end else begin
              mem_re = 1'b1; mem_raddr = adr[AW+1:2];
              state_nxt = S_MEMWB;
            end
          end
          tfr_pkg::OP_STW: begin
            if (!adr_ok) begin
              fault_nxt = tfr_pkg::FLT_WADR; status_nxt = ST_FAULT; state_nxt = S_DONE;
            end else begin
              mem_we = 1'b1; mem_waddr = adr[AW+1:2]; mem_wdata = ra;
            end
          end
          tfr_pkg::OP_PSH: begin
            if (!adr_ok) begin
              fault_nxt = tfr_pkg::FLT_WADR; status_nxt = ST_FAULT; state_nxt = S_DONE;
            end else begin
              // b is lowered first, so a equal to b stores the lowered value
              rf_we = 1'b1; rf_waddr = fb; rf_wdata = adr;
              mem_we = 1'b1; mem_waddr = adr[AW+1:2];
              mem_wdata = (fa == fb) ? adr : ra;
            end
          end
          tfr_pkg::OP_RD, tfr_pkg::OP_RB: used_nxt = 1'b1;
          tfr_pkg::OP_WRD: begin
            kind_nxt = tfr_pkg::KIND_DEC; val_nxt = rx_r;
          end
          tfr_pkg::OP_WRH: begin
            kind_nxt = tfr_pkg::KIND_HEX; val_nxt = rx_r;
          end
          tfr_pkg::OP_WRL: kind_nxt = tfr_pkg::KIND_NL;
          tfr_pkg::OP_WRB: begin
            kind_nxt = tfr_pkg::KIND_BYTE; val_nxt = rx_r & 32'h0000_00ff;
          end
          tfr_pkg::OP_BEQ: if (z_r) next_nxt = br_tgt;
          tfr_pkg::OP_BNE: if (!z_r) next_nxt = br_tgt;
          tfr_pkg::OP_BLT: if (n_r) next_nxt = br_tgt;
          tfr_pkg::OP_BGE: if (!n_r) next_nxt = br_tgt;
          tfr_pkg::OP_BLE: if (z_r || n_r) next_nxt = br_tgt;
          tfr_pkg::OP_BGT: if (!z_r && !n_r) next_nxt = br_tgt;
          tfr_pkg::OP_BR:  next_nxt = br_tgt;
          tfr_pkg::OP_BSR: begin
            next_nxt = br_tgt;
            rf_we = 1'b1; rf_waddr = tfr_pkg::REG_LINK; rf_wdata = pc4;
          end
          tfr_pkg::OP_RET: next_nxt = rx_r;
          default: begin
            fault_nxt = tfr_pkg::FLT_OPC; status_nxt = ST_FAULT; state_nxt = S_DONE;
          end
        endcase
      end

      // One multiply or divide bit per cycle through the shared adder
      S_ITER: begin
        if (md_mul) begin
          acc_nxt   = alu_sum[31:0];
          mcand_nxt = {mcand_r[30:0], 1'b0};
          mq_nxt    = {1'b0, mq_r[31:1]};
        end else begin
          acc_nxt = ge ? alu_sum[31:0] : alu_a[31:0];
          mq_nxt  = {mq_r[30:0], ge};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_MDFIN;
        end
      end

      // Product, or signs back onto quotient or remainder, into a
      S_MDFIN: begin
        rf_we = 1'b1; rf_waddr = fa;
        if (md_mul) begin
          rf_wdata = acc_r;
        end else if (opc == tfr_pkg::OP_DIV || opc == tfr_pkg::OP_DIVI) begin
          rf_wdata = (sx_r ^ sy_r) ? (32'd0 - mq_r) : mq_r;
        end else begin
          rf_wdata = (sx_r && acc_r != 32'd0) ? (mcand_r - acc_r) : acc_r;
        end
        state_nxt = S_COMMIT;
      end

      // Memory data back for loads, pop and byte store
      S_MEMWB: begin
        state_nxt = S_COMMIT;
        case (opc)
          tfr_pkg::OP_LDB: begin
            rf_we = 1'b1; rf_waddr = fa; rf_wdata = lane_byte;
          end
          tfr_pkg::OP_STB: begin
            mem_we = 1'b1; mem_waddr = adr_r[AW+1:2];
            mem_wdata = (mem_rdata_r & ~(32'h0000_00ff << lane_sh)) |
                        ((ra & 32'h0000_00ff) << lane_sh);
          end
          tfr_pkg::OP_POP: begin
            rf_we = 1'b1; rf_waddr = fa; rf_wdata = mem_rdata_r;
            tmp_nxt = ((fa == fb) ? mem_rdata_r : rb_r) + cval;
            state_nxt = S_WB2;
          end
          default: begin
            rf_we = 1'b1; rf_waddr = fa; rf_wdata = mem_rdata_r;
          end
        endcase
      end

      // Pop: raise b after a is written
      S_WB2: begin
        rf_we = 1'b1; rf_waddr = fb; rf_wdata = tmp_r;
        state_nxt = S_COMMIT;
      end

      // Next address, halt on zero, read value into a
      S_COMMIT: begin
        if (used_r) begin
          rf_we = 1'b1; rf_waddr = fa; rf_wdata = rdv_r;
          pc_nxt = (fa == tfr_pkg::REG_PC) ? rdv_r : next_r;
        end else if (next_r == 32'd0) begin
          status_nxt = ST_HALT;
          pc_nxt = '0;
        end else begin
          pc_nxt = next_r;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt   = 1'b1;
          out_kind_nxt  = kind_r;
          out_val_nxt   = val_r;
          out_used_nxt  = used_r;
          out_halt_nxt  = (status_r == ST_HALT);
          out_fault_nxt = fault_r;
          out_pc_nxt    = pc_r[11:0];
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  status_r <= ST_IDLE; fault_r <= tfr_pkg::FLT_NONE;
      pc_r <= '0;  ir_r <= '0;  z_r <= 1'b0;  n_r <= 1'b0;
      kind_r <= tfr_pkg::KIND_NONE;  val_r <= '0;  used_r <= 1'b0;
      cnt_r <= '0;  out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  status_r <= status_nxt;  fault_r <= fault_nxt;
      pc_r <= pc_nxt;  ir_r <= ir_nxt;  z_r <= z_nxt;  n_r <= n_nxt;
      kind_r <= kind_nxt;  val_r <= val_nxt;  used_r <= used_nxt;
      cnt_r <= cnt_nxt;  out_vld_r <= out_vld_nxt;
    end
    rdv_r <= rdv_nxt;  rb_r <= rb_nxt;  rx_r <= rx_nxt;  next_r <= next_nxt;
    tmp_r <= tmp_nxt;  adr_r <= adr_nxt;  acc_r <= acc_nxt;
    mcand_r <= mcand_nxt;  mq_r <= mq_nxt;  sx_r <= sx_nxt;  sy_r <= sy_nxt;
    out_kind_r <= out_kind_nxt;  out_val_r <= out_val_nxt;
    out_used_r <= out_used_nxt;  out_halt_r <= out_halt_nxt;
    out_fault_r <= out_fault_nxt;  out_pc_r <= out_pc_nxt;
  end

  // Word memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // Register file: unwritten entries read zero, R15 reads the program counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[rf_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_re) begin
      rd0_r <= (rf_ra0 == tfr_pkg::REG_PC) ? pc_r :
               (rf_vld_r[rf_ra0] ? rf_mem[rf_ra0] : 32'd0);
      rd1_r <= (rf_ra1 == tfr_pkg::REG_PC) ? pc_r :
               (rf_vld_r[rf_ra1] ? rf_mem[rf_ra1] : 32'd0);
    end
  end

`ifndef SYNTHESIS
  // A faulted core always holds a fault code
  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == ST_FAULT) |-> (fault_r != tfr_pkg::FLT_NONE))
    else $error("faulted without fault code");

  // Halt leaves the program counter at zero
  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == ST_HALT) |-> (pc_r == 32'd0))
    else $error("halted with nonzero pc");

  // A blocked result keeps the sequencer waiting in its last state
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_vld_r && !out_ch.ready) |=> (state_r == S_DONE))
    else $error("result register overrun");
`endif

endmodule
